### rtl/psrb_pkg.sv
// Shared types and constants of the packet sequence reorder buffer.
`default_nettype none

package psrb_pkg;

    localparam int unsigned WINDOW_DEF   = 8;
    localparam int unsigned TAG_BITS_DEF = 16;

    localparam int unsigned SEQ_W  = 32;
    localparam int unsigned TAG_W  = 16;
    localparam int unsigned FUNC_W = 2;
    localparam int unsigned THR_W  = 4;
    localparam int unsigned IDX_W  = 6;   // slot index, covers the largest window
    localparam int unsigned CNT_W  = 8;   // held count and threshold compare width

    localparam logic [THR_W-1:0] THR_RESET = 4'd8;

    localparam logic [FUNC_W-1:0] FUNC_ARRIVE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [TAG_W-1:0] hit_tag;
        logic             any;
        logic [IDX_W-1:0] min_idx;
        logic [SEQ_W-1:0] min_seq;
        logic [TAG_W-1:0] min_tag;
        logic             free;
        logic [IDX_W-1:0] free_idx;
    } t_scan;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] skip;
        logic             last;
    } t_result;

endpackage

`default_nettype wire

### rtl/psrb_if.sv
// Handshake channel interfaces of the packet sequence reorder buffer.
`default_nettype none

interface psrb_in_if;
    logic                        valid;
    logic                        ready;
    logic [psrb_pkg::FUNC_W-1:0] func;
    logic [psrb_pkg::SEQ_W-1:0]  seq_number;
    logic [psrb_pkg::TAG_W-1:0]  packet_tag;

    modport source (output valid, output func, output seq_number, output packet_tag,
                    input ready);
    modport sink   (input valid, input func, input seq_number, input packet_tag,
                    output ready);
endinterface

interface psrb_out_if;
    logic                       valid;
    logic                       ready;
    logic [psrb_pkg::TAG_W-1:0] out_tag;
    logic [psrb_pkg::SEQ_W-1:0] out_seq;
    logic [psrb_pkg::SEQ_W-1:0] skipped_before;
    logic                       last;

    modport source (output valid, output out_tag, output out_seq, output skipped_before,
                    output last, input ready);
    modport sink   (input valid, input out_tag, input out_seq, input skipped_before,
                    input last, output ready);
endinterface

interface psrb_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [psrb_pkg::THR_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/psrb_mem.sv
// Slot store: one write port, one read port with registered read data.
`default_nettype none

module psrb_mem #(
    parameter int unsigned DEPTH = psrb_pkg::WINDOW_DEF,
    parameter int unsigned WIDTH = psrb_pkg::SEQ_W + psrb_pkg::TAG_W,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/psrb_scan.sv
// Shared slot compare unit: match, minimum and first free slot, one slot per enabled cycle.
`default_nettype none

module psrb_scan #(
    parameter int unsigned WINDOW = psrb_pkg::WINDOW_DEF,
    localparam int unsigned AW    = $clog2(WINDOW)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_clr,
    input  wire logic                       i_en,
    input  wire logic [AW-1:0]              i_idx,
    input  wire logic                       i_slot_vld,
    input  wire logic [psrb_pkg::SEQ_W-1:0] i_seq,
    input  wire logic [psrb_pkg::TAG_W-1:0] i_tag,
    input  wire logic [psrb_pkg::SEQ_W-1:0] i_key,
    output psrb_pkg::t_scan                 o_res
);

    psrb_pkg::t_scan r_res;
    logic            eq;
    logic            le;

    assign eq = (i_seq == i_key);
    assign le = (i_seq <= r_res.min_seq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_res.hit  <= 1'b0;
            r_res.any  <= 1'b0;
            r_res.free <= 1'b0;
        end else if (i_en) begin
            if (i_slot_vld && eq && !r_res.hit) begin
                r_res.hit     <= 1'b1;
                r_res.hit_idx <= psrb_pkg::IDX_W'(i_idx);
                r_res.hit_tag <= i_tag;
            end
            if (i_slot_vld && (!r_res.any || le)) begin
                r_res.any     <= 1'b1;
                r_res.min_idx <= psrb_pkg::IDX_W'(i_idx);
                r_res.min_seq <= i_seq;
                r_res.min_tag <= i_tag;
            end
            if (!i_slot_vld && !r_res.free) begin
                r_res.free     <= 1'b1;
                r_res.free_idx <= psrb_pkg::IDX_W'(i_idx);
            end
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

### rtl/packet_sequence_reorder_buffer_unit.sv
// Packet sequence reorder buffer: top level with sequencer and output register.
//
// Input channel i_in carries one word per command: func 0 delivers a packet
// (seq_number, packet_tag), func 1 flushes all held packets, func 2 clears the
// session. Output channel o_out returns released packets in sequence order,
// with the count of numbers skipped before each and last set on the final one
// of a command. i_cfg writes the 4-bit reorder threshold, taken every cycle.
// Packets and flushes work through the slot store with one compare unit that
// looks at one slot per cycle. A packet is accepted, then gets one pass for the
// duplicate and free slot check (a duplicate, or a packet that finds no free
// slot, ends there), then one pass per released packet plus a final pass and
// the closing state. A flush is the same without the first pass; a clear or a
// dropped packet is done once accepted. i_in.ready is high only between commands.
// Results leave through a one-word output register; a stalled receiver holds
// the sequencer at the next release, while a new command may be accepted with
// the final word still waiting. Reset (synchronous, active low) clears the
// store, the last delivered number and the output, and sets the threshold to 8.
`default_nettype none

module packet_sequence_reorder_buffer_unit #(
    parameter int unsigned WINDOW   = psrb_pkg::WINDOW_DEF,
    parameter int unsigned TAG_BITS = psrb_pkg::TAG_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    psrb_in_if.sink    i_in,
    psrb_out_if.source o_out,
    psrb_cfg_if.sink   i_cfg
);

    localparam int unsigned AW = $clog2(WINDOW);
    localparam int unsigned HW = $clog2(WINDOW + 1);
    localparam int unsigned TW = (TAG_BITS < psrb_pkg::TAG_W) ? TAG_BITS : psrb_pkg::TAG_W;
    localparam int unsigned MW = psrb_pkg::SEQ_W + TW;
    localparam logic [psrb_pkg::CNT_W-1:0] WIN_C = psrb_pkg::CNT_W'(WINDOW);

    psrb_pkg::t_state r_state;
    psrb_pkg::t_state n_state;

    logic [psrb_pkg::THR_W-1:0] r_thr;
    logic [psrb_pkg::SEQ_W-1:0] r_last;
    logic [WINDOW-1:0]          r_valid;
    logic [HW-1:0]              r_held;
    logic                       r_drain;
    logic                       r_force;
    logic [psrb_pkg::SEQ_W-1:0] r_key;
    logic [TW-1:0]              r_tag;
    logic [HW-1:0]              r_cnt;
    logic                       r_pvld;
    logic [AW-1:0]              r_pidx;
    logic                       r_pend_vld;
    psrb_pkg::t_result          r_pend;
    logic                       r_out_vld;
    psrb_pkg::t_result          r_out;

    logic                       in_acc;
    logic                       in_go;
    logic                       scan_done;
    logic                       out_free;
    logic [psrb_pkg::CNT_W-1:0] thr_ext;
    logic [psrb_pkg::CNT_W-1:0] thr_eff;
    logic                       below_thr;
    logic                       ins_ok;
    logic                       d_end;
    logic                       d_stall;
    logic [AW-1:0]              emit_idx;
    logic [psrb_pkg::SEQ_W-1:0] emit_seq;
    psrb_pkg::t_result          emit_res;

    logic                       c_start;
    logic                       c_issue;
    logic                       c_ins;
    logic                       c_emit;
    logic                       c_push;
    logic                       c_fin_push;
    logic                       c_clear;

    psrb_pkg::t_scan            res;
    logic [MW-1:0]              rdata;
    logic [psrb_pkg::SEQ_W-1:0] rd_seq;
    logic [psrb_pkg::TAG_W-1:0] rd_tag;

    psrb_mem #(
        .DEPTH (WINDOW),
        .WIDTH (MW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (c_ins),
        .i_waddr (res.free_idx[AW-1:0]),
        .i_wdata ({r_key, r_tag}),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (rdata)
    );

    assign rd_seq = rdata[MW-1:TW];
    assign rd_tag = psrb_pkg::TAG_W'(rdata[TW-1:0]);

    psrb_scan #(
        .WINDOW (WINDOW)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clr      (c_start),
        .i_en       (r_pvld),
        .i_idx      (r_pidx),
        .i_slot_vld (r_valid[r_pidx]),
        .i_seq      (rd_seq),
        .i_tag      (rd_tag),
        .i_key      (r_key),
        .o_res      (res)
    );

    assign in_acc    = i_in.valid && i_in.ready;
    assign in_go     = ((i_in.func == psrb_pkg::FUNC_ARRIVE) && (i_in.seq_number > r_last))
                    || (i_in.func == psrb_pkg::FUNC_FLUSH);
    assign scan_done = (r_cnt == HW'(WINDOW)) && !r_pvld;
    assign out_free  = !r_out_vld || o_out.ready;

    assign thr_ext   = psrb_pkg::CNT_W'(r_thr);
    assign thr_eff   = (thr_ext == '0) ? psrb_pkg::CNT_W'(1)
                     : ((thr_ext > WIN_C) ? WIN_C : thr_ext);
    assign below_thr = psrb_pkg::CNT_W'(r_held) < thr_eff;

    assign ins_ok    = !res.hit && res.free;
    assign d_end     = (r_held == '0) || (!res.hit && !r_force && below_thr);
    assign d_stall   = r_pend_vld && !out_free;

    assign emit_idx      = res.hit ? res.hit_idx[AW-1:0] : res.min_idx[AW-1:0];
    assign emit_seq      = res.hit ? r_key : res.min_seq;
    assign emit_res.tag  = res.hit ? res.hit_tag : res.min_tag;
    assign emit_res.seq  = emit_seq;
    assign emit_res.skip = res.hit ? '0 : (res.min_seq - r_key);
    assign emit_res.last = 1'b0;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            psrb_pkg::ST_IDLE: begin
                if (in_acc && in_go) begin
                    n_state = psrb_pkg::ST_SCAN;
                end
            end
            psrb_pkg::ST_SCAN: begin
                if (scan_done) begin
                    if (!r_drain) begin
                        n_state = ins_ok ? psrb_pkg::ST_SCAN : psrb_pkg::ST_IDLE;
                    end else if (d_end) begin
                        n_state = psrb_pkg::ST_FIN;
                    end
                end
            end
            psrb_pkg::ST_FIN: begin
                if (!r_pend_vld || out_free) begin
                    n_state = psrb_pkg::ST_IDLE;
                end
            end
            default: n_state = psrb_pkg::ST_IDLE;
        endcase
    end

    // sequencer controls
    always_comb begin
        c_issue    = 1'b0;
        c_ins      = 1'b0;
        c_emit     = 1'b0;
        c_fin_push = 1'b0;
        c_clear    = 1'b0;
        c_start    = 1'b0;
        unique case (r_state)
            psrb_pkg::ST_IDLE: begin
                c_start = in_acc && in_go;
                c_clear = in_acc && (i_in.func == psrb_pkg::FUNC_CLEAR);
            end
            psrb_pkg::ST_SCAN: begin
                c_issue = r_cnt < HW'(WINDOW);
                c_ins   = scan_done && !r_drain && ins_ok;
                c_emit  = scan_done && r_drain && !d_end && !d_stall;
                c_start = c_ins || c_emit;
            end
            psrb_pkg::ST_FIN: begin
                c_fin_push = r_pend_vld && out_free;
            end
            default: begin
            end
        endcase
        c_push = (c_emit && r_pend_vld) || c_fin_push;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= psrb_pkg::ST_IDLE;
            r_thr      <= psrb_pkg::THR_RESET;
            r_last     <= '0;
            r_valid    <= '0;
            r_held     <= '0;
            r_drain    <= 1'b0;
            r_force    <= 1'b0;
            r_cnt      <= '0;
            r_pvld     <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_thr <= i_cfg.data;
            end
            if (c_clear) begin
                r_last  <= '0;
                r_valid <= '0;
                r_held  <= '0;
            end
            if (in_acc) begin
                r_drain <= (i_in.func == psrb_pkg::FUNC_FLUSH);
                r_force <= (i_in.func == psrb_pkg::FUNC_FLUSH);
                r_key   <= (i_in.func == psrb_pkg::FUNC_FLUSH) ? r_last + 1'b1
                                                               : i_in.seq_number;
                r_tag   <= i_in.packet_tag[TW-1:0];
            end
            if (c_ins) begin
                r_valid[res.free_idx[AW-1:0]] <= 1'b1;
                r_held  <= r_held + 1'b1;
                r_drain <= 1'b1;
                r_key   <= r_last + 1'b1;
            end
            if (c_emit) begin
                r_valid[emit_idx] <= 1'b0;
                r_held     <= r_held - 1'b1;
                r_last     <= emit_seq;
                r_key      <= emit_seq + 1'b1;
                r_pend_vld <= 1'b1;
                r_pend     <= emit_res;
            end
            if (c_fin_push) begin
                r_pend_vld <= 1'b0;
            end
            if (c_start) begin
                r_cnt <= '0;
            end else if (c_issue) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_pvld <= c_issue;
            if (c_push) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
        r_pidx <= r_cnt[AW-1:0];
        if (c_push) begin
            r_out <= '{tag: r_pend.tag, seq: r_pend.seq, skip: r_pend.skip,
                       last: c_fin_push};
        end
    end

    assign i_in.ready           = (r_state == psrb_pkg::ST_IDLE);
    assign i_cfg.ready          = 1'b1;
    assign o_out.valid          = r_out_vld;
    assign o_out.out_tag        = r_out.tag;
    assign o_out.out_seq        = r_out.seq;
    assign o_out.skipped_before = r_out.skip;
    assign o_out.last           = r_out.last;

    a_held_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_held) == $countones(r_valid))
        else $error("held count out of step with slot valid bits");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.func == psrb_pkg::FUNC_CLEAR) |=> (r_held == '0 && r_last == '0))
        else $error("session clear left state behind");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psrb_pkg::ST_IDLE) |-> !r_pend_vld)
        else $error("idle with an unsent word");

    a_pend_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> (r_pend.seq == r_last))
        else $error("pending word does not match last delivered number");

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for the packet sequence reorder buffer unit.
`default_nettype none

module tb;

    localparam int WIN = psrb_pkg::WINDOW_DEF;
    localparam logic [psrb_pkg::FUNC_W-1:0] FUNC_NOP = 2'd3;
    localparam int SETTLE_CYC = 100;
    localparam int PHASE_ITEMS = 88;
    localparam int NUM_PHASES = 5;

    typedef struct packed {
        logic [psrb_pkg::FUNC_W-1:0] func;
        logic [psrb_pkg::SEQ_W-1:0]  seq;
        logic [psrb_pkg::TAG_W-1:0]  tag;
    } t_pkt_cmd;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    psrb_in_if  in_ch();
    psrb_out_if out_ch();
    psrb_cfg_if cfg_ch();

    packet_sequence_reorder_buffer_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    t_pkt_cmd          cmd_q[$];
    psrb_pkg::t_result release_q[$];
    t_pkt_cmd          next_cmd;
    psrb_pkg::t_result due;
    int       mismatches = 0;
    int       snd_idle_pct = 0;
    int       rcv_stall_pct = 0;
    logic [psrb_pkg::SEQ_W-1:0] gen_cursor = 32'd2;

    // reorder state mirror
    logic [psrb_pkg::THR_W-1:0] thr_m = psrb_pkg::THR_RESET;
    logic [psrb_pkg::SEQ_W-1:0] delivered_m;
    logic                       held_v[WIN];
    logic [psrb_pkg::SEQ_W-1:0] held_seq[WIN];
    logic [psrb_pkg::TAG_W-1:0] held_tag[WIN];

    function automatic int held_count();
        int n;
        n = 0;
        for (int i = 0; i < WIN; i++)
            if (held_v[i]) n++;
        return n;
    endfunction

    function automatic void clear_session_m();
        delivered_m = '0;
        for (int i = 0; i < WIN; i++) begin
            held_v[i] = 1'b0;
            held_seq[i] = '0;
            held_tag[i] = '0;
        end
    endfunction

    function automatic void release_in_order(input bit flush_all);
        psrb_pkg::t_result burst[$];
        psrb_pkg::t_result r;
        logic [psrb_pkg::SEQ_W-1:0] want;
        logic [psrb_pkg::SEQ_W-1:0] low;
        logic [psrb_pkg::SEQ_W-1:0] skip;
        int hit;
        int lim;
        skip = '0;
        lim = (thr_m == 0) ? 1 : (thr_m > WIN) ? WIN : int'(thr_m);
        while (held_count() > 0 && burst.size() < WIN) begin
            want = delivered_m + 1;
            hit = -1;
            for (int i = 0; i < WIN; i++)
                if (hit < 0 && held_v[i] && held_seq[i] == want) hit = i;
            if (hit >= 0) begin
                r.tag = held_tag[hit];
                r.seq = want;
                r.skip = skip;
                r.last = 1'b0;
                burst = {burst, r};
                skip = '0;
                held_v[hit] = 1'b0;
                delivered_m = want;
            end else if (!flush_all && held_count() < lim) begin
                break;
            end else begin
                // gap declared lost: jump to the smallest held number
                low = '1;
                for (int i = 0; i < WIN; i++)
                    if (held_v[i] && held_seq[i] <= low) low = held_seq[i];
                skip = low - want;
                delivered_m = low - 1;
            end
        end
        if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
        release_q = {release_q, burst};
    endfunction

    function automatic void predict_cmd(input logic [psrb_pkg::FUNC_W-1:0] f,
                                        input logic [psrb_pkg::SEQ_W-1:0] s,
                                        input logic [psrb_pkg::TAG_W-1:0] t);
        int slot;
        bit dup;
        slot = -1;
        dup = 1'b0;
        case (f)
            psrb_pkg::FUNC_FLUSH: release_in_order(1'b1);
            psrb_pkg::FUNC_CLEAR: clear_session_m();
            psrb_pkg::FUNC_ARRIVE: begin
                if (s > delivered_m) begin
                    for (int i = 0; i < WIN; i++) begin
                        if (held_v[i] && held_seq[i] == s) dup = 1'b1;
                        else if (!held_v[i] && slot < 0) slot = i;
                    end
                    if (!dup && slot >= 0) begin
                        held_v[slot] = 1'b1;
                        held_seq[slot] = s;
                        held_tag[slot] = t;
                        release_in_order(1'b0);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", field, got, want, $realtime);
        mismatches++;
    endtask

    task automatic push_cmd(input logic [psrb_pkg::FUNC_W-1:0] f,
                            input logic [psrb_pkg::SEQ_W-1:0] s,
                            input logic [psrb_pkg::TAG_W-1:0] t);
        t_pkt_cmd c;
        c.func = f;
        c.seq = s;
        c.tag = t;
        cmd_q = {cmd_q, c};
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.func <= psrb_pkg::FUNC_ARRIVE;
            in_ch.seq_number <= '0;
            in_ch.packet_tag <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                predict_cmd(in_ch.func, in_ch.seq_number, in_ch.packet_tag);
            if (!in_ch.valid || in_ch.ready) begin
                if (cmd_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                    next_cmd = cmd_q.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.func <= next_cmd.func;
                    in_ch.seq_number <= next_cmd.seq;
                    in_ch.packet_tag <= next_cmd.tag;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (release_q.size() == 0) begin
                    report_mismatch("unexpected word, seq", out_ch.out_seq, '0);
                end else begin
                    due = release_q.pop_front();
                    if (out_ch.out_tag !== due.tag)
                        report_mismatch("out_tag", 32'(out_ch.out_tag), 32'(due.tag));
                    if (out_ch.out_seq !== due.seq)
                        report_mismatch("out_seq", out_ch.out_seq, due.seq);
                    if (out_ch.skipped_before !== due.skip)
                        report_mismatch("skipped_before", out_ch.skipped_before, due.skip);
                    if (out_ch.last !== due.last)
                        report_mismatch("last", 32'(out_ch.last), 32'(due.last));
                end
            end
            out_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    task automatic load_directed();
        push_cmd(psrb_pkg::FUNC_ARRIVE, 32'd1, 16'hFFFF);
        push_cmd(psrb_pkg::FUNC_ARRIVE, 32'd3, 16'h0001);
        push_cmd(psrb_pkg::FUNC_ARRIVE, 32'd2, 16'h8000);
        push_cmd(psrb_pkg::FUNC_ARRIVE, 32'd5, 16'h1234);
        push_cmd(psrb_pkg::FUNC_ARRIVE, 32'd5, 16'h4321);
        push_cmd(psrb_pkg::FUNC_ARRIVE, 32'd1, 16'h0002);
        push_cmd(psrb_pkg::FUNC_ARRIVE, 32'd0, 16'h0003);
        push_cmd(psrb_pkg::FUNC_FLUSH, 32'd0, 16'h0000);
        push_cmd(FUNC_NOP, 32'd7, 16'h00AA);
        for (int i = 0; i < WIN; i++)
            push_cmd(psrb_pkg::FUNC_ARRIVE, 32'(32'd7 + 2 * i), 16'($urandom));
        push_cmd(psrb_pkg::FUNC_FLUSH, '1, '1);
        push_cmd(psrb_pkg::FUNC_CLEAR, 32'd0, 16'h0000);
        push_cmd(psrb_pkg::FUNC_ARRIVE, '1, 16'h0000);
        push_cmd(psrb_pkg::FUNC_FLUSH, 32'd0, 16'h0000);
        push_cmd(psrb_pkg::FUNC_ARRIVE, '1, 16'h5555);
        push_cmd(psrb_pkg::FUNC_ARRIVE, 32'd1, 16'hAAAA);
        push_cmd(psrb_pkg::FUNC_CLEAR, '1, '1);
        push_cmd(psrb_pkg::FUNC_ARRIVE, 32'd1, 16'h0000);
    endtask

    task automatic gen_phase(input int target);
        logic [psrb_pkg::SEQ_W-1:0] seqs[$];
        logic [psrb_pkg::SEQ_W-1:0] tmp;
        int made;
        int roll;
        int k;
        int cut;
        made = 0;
        while (made < target) begin
            roll = $urandom_range(99);
            if (roll < 5) begin
                push_cmd(psrb_pkg::FUNC_CLEAR, $urandom, 16'($urandom));
                gen_cursor = $urandom_range(1, 40);
                made++;
            end else if (roll < 13) begin
                push_cmd(psrb_pkg::FUNC_FLUSH, $urandom, 16'($urandom));
                made++;
            end else if (roll < 16) begin
                push_cmd(FUNC_NOP, $urandom, 16'($urandom));
            end else if (roll < 26) begin
                push_cmd(psrb_pkg::FUNC_ARRIVE,
                         (roll < 21) ? $urandom : gen_cursor - $urandom_range(0, 4),
                         16'($urandom));
                made++;
            end else begin
                if ($urandom_range(11) == 0)
                    gen_cursor = $urandom_range(1) ? $urandom : 32'hFFFF_FFF0 + $urandom_range(0, 8);
                if ($urandom_range(3) == 0) gen_cursor += $urandom_range(1, 3);
                k = $urandom_range(1, WIN + 1);
                seqs.delete();
                for (int j = 0; j < k; j++) seqs = {seqs, 32'(gen_cursor + j)};
                gen_cursor += k;
                if (k > 1 && $urandom_range(4) == 0) seqs.delete($urandom_range(0, k - 1));
                for (int j = seqs.size() - 1; j > 0; j--) begin
                    cut = $urandom_range(0, j);
                    tmp = seqs[j];
                    seqs[j] = seqs[cut];
                    seqs[cut] = tmp;
                end
                foreach (seqs[j]) begin
                    push_cmd(psrb_pkg::FUNC_ARRIVE, seqs[j], 16'($urandom));
                    made++;
                    if ($urandom_range(9) == 0) begin
                        push_cmd(psrb_pkg::FUNC_ARRIVE, seqs[j], 16'($urandom));
                        made++;
                    end
                end
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (cmd_q.size() != 0 || in_ch.valid || release_q.size() != 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [psrb_pkg::THR_W-1:0] v);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= v;
        do @(posedge i_clk);
        while (!cfg_ch.ready);
        thr_m = v;
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        logic [psrb_pkg::THR_W-1:0] phase_thr[NUM_PHASES];
        int phase_snd[NUM_PHASES];
        int phase_rcv[NUM_PHASES];
        phase_thr = '{4'd1, 4'd15, 4'd0, 4'($urandom_range(2, 7)), 4'd8};
        phase_snd = '{0, 74, 0, 35, 0};
        phase_rcv = '{0, 0, 74, 35, 0};
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        clear_session_m();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        load_directed();
        wait_drained();
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_threshold(phase_thr[p]);
            @(negedge i_clk);
            snd_idle_pct = phase_snd[p];
            rcv_stall_pct = phase_rcv[p];
            gen_phase(PHASE_ITEMS);
            wait_drained();
        end
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #(10 * 1_500_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
